### rtl/nse_pkg.sv
// Package: request types and controller states for the next smaller element stack.
`timescale 1ns / 1ps
`default_nettype none

package nse_pkg;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 6;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } item_req_t;

    typedef struct packed {
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] next_smaller;
        logic                      found;
        logic                      overflow;
        logic                      end_of_run;
    } result_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_LOAD,
        ST_FL_RD,
        ST_FL_EM,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

### rtl/next_smaller_element_stack.sv
// Top level: next smaller element finder built on a monotonic stack held in one memory.
// Steps: an accepted item is compared with the stack top; each popped entry gives a result,
// then the new top is read from memory and loaded before the next compare, unless the stack is empty.
// A last item then flushes the stack with one memory read per entry, bottom entry first.
// A new item is taken only once the last one is done; result stalls can hold the controller.
// Reset clears the counters and handshake state; the stack memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module next_smaller_element_stack #(
    parameter int MAX_LEN    = 64,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_stall,
    input  wire nse_pkg::item_req_t   item,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output nse_pkg::result_req_t      result
);

    localparam int  SW         = (VALUE_BITS < nse_pkg::VALUE_W) ? VALUE_BITS : nse_pkg::VALUE_W;
    localparam bit  SIGNED_CMP = (VALUE_BITS <= nse_pkg::VALUE_W);
    localparam int  CW         = $clog2(MAX_LEN + 1);
    localparam int  AW         = $clog2(MAX_LEN);
    localparam int  EW         = nse_pkg::POS_W + SW;

    function automatic logic is_less(input logic [SW-1:0] a, input logic [SW-1:0] b);
        if (SIGNED_CMP)
            return $signed(a) < $signed(b);
        else
            return a < b;
    endfunction

    // stack memory: {position, value}
    logic [EW-1:0] mem [MAX_LEN];
    logic [EW-1:0] rd_data_reg;

    nse_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   items_reg, items_next;
    logic [CW-1:0]   fi_reg, fi_next;
    logic            hold_valid_reg, hold_valid_next;
    logic            out_valid_reg, out_valid_next;

    logic [SW-1:0]              v_reg;
    logic                       last_reg;
    logic                       rej_reg;
    logic [SW-1:0]              top_val_reg;
    logic [nse_pkg::POS_W-1:0]  top_pos_reg;
    nse_pkg::result_req_t       hold_reg;
    nse_pkg::result_req_t       out_reg;

    logic                 slot_free;
    logic                 can_produce;
    logic                 accept;
    logic                 produce;
    logic                 finish;
    logic                 do_pop;
    logic                 do_push;
    logic                 load_top;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    nse_pkg::result_req_t new_res;
    logic                 pop_cond;

    assign slot_free    = !out_valid_reg || !result_stall;
    assign can_produce  = !hold_valid_reg || slot_free;
    assign item_stall   = (state_reg != nse_pkg::ST_IDLE);
    assign accept       = item_valid && !item_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign pop_cond     = !rej_reg && (count_reg != '0) && is_less(v_reg, top_val_reg);

    // controls
    always_comb
    begin
        produce  = 1'b0;
        finish   = 1'b0;
        do_pop   = 1'b0;
        do_push  = 1'b0;
        load_top = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = '0;
        new_res  = '0;
        case (state_reg)
            nse_pkg::ST_CMP:
            begin
                if (pop_cond)
                begin
                    if (can_produce)
                    begin
                        produce              = 1'b1;
                        do_pop               = 1'b1;
                        new_res.position     = top_pos_reg;
                        new_res.next_smaller = nse_pkg::VALUE_W'(v_reg);
                        new_res.found        = 1'b1;
                        rd_en                = (count_reg > CW'(1));
                        rd_addr              = AW'(count_reg - CW'(2));
                    end
                end
                else if (!rej_reg)
                begin
                    do_push = 1'b1;
                end
                else if (!last_reg && can_produce)
                begin
                    produce          = 1'b1;
                    new_res.overflow = 1'b1;
                end
            end
            nse_pkg::ST_LOAD:
            begin
                load_top = 1'b1;
            end
            nse_pkg::ST_FL_RD:
            begin
                rd_en   = (fi_reg < count_reg);
                rd_addr = fi_reg[AW-1:0];
            end
            nse_pkg::ST_FL_EM:
            begin
                if (can_produce)
                begin
                    produce          = 1'b1;
                    new_res.position = rd_data_reg[EW-1:SW];
                    new_res.overflow = rej_reg;
                end
            end
            nse_pkg::ST_DONE:
            begin
                finish = can_produce;
            end
            default:
            begin
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nse_pkg::ST_IDLE:
                if (accept)
                    state_next = nse_pkg::ST_CMP;
            nse_pkg::ST_CMP:
                if (do_pop)
                    state_next = rd_en ? nse_pkg::ST_LOAD : nse_pkg::ST_CMP;
                else if (do_push)
                    state_next = last_reg ? nse_pkg::ST_FL_RD : nse_pkg::ST_DONE;
                else if (rej_reg && last_reg)
                    state_next = nse_pkg::ST_FL_RD;
                else if (produce)
                    state_next = nse_pkg::ST_DONE;
            nse_pkg::ST_LOAD:
                state_next = nse_pkg::ST_CMP;
            nse_pkg::ST_FL_RD:
                state_next = rd_en ? nse_pkg::ST_FL_EM : nse_pkg::ST_DONE;
            nse_pkg::ST_FL_EM:
                if (produce)
                    state_next = nse_pkg::ST_FL_RD;
            nse_pkg::ST_DONE:
                if (finish)
                    state_next = nse_pkg::ST_IDLE;
            default:
                state_next = nse_pkg::ST_IDLE;
        endcase
    end

    // counters and handshake flags
    always_comb
    begin
        count_next      = count_reg;
        items_next      = items_reg;
        fi_next         = fi_reg;
        hold_valid_next = hold_valid_reg;
        out_valid_next  = out_valid_reg;
        if (accept)
            fi_next = '0;
        if (do_pop)
            count_next = count_reg - CW'(1);
        if (do_push)
        begin
            count_next = count_reg + CW'(1);
            items_next = items_reg + CW'(1);
        end
        if (state_reg == nse_pkg::ST_FL_EM && produce)
            fi_next = fi_reg + CW'(1);
        if (!result_stall)
            out_valid_next = 1'b0;
        if ((produce || finish) && hold_valid_reg)
            out_valid_next = 1'b1;
        if (produce)
            hold_valid_next = 1'b1;
        else if (finish)
            hold_valid_next = 1'b0;
        if (finish && last_reg)
        begin
            count_next = '0;
            items_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= nse_pkg::ST_IDLE;
            count_reg      <= '0;
            items_reg      <= '0;
            fi_reg         <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            items_reg      <= items_next;
            fi_reg         <= fi_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            v_reg    <= item.value[SW-1:0];
            last_reg <= item.last;
            rej_reg  <= (items_reg >= CW'(MAX_LEN));
        end
        if (do_push)
        begin
            top_val_reg <= v_reg;
            top_pos_reg <= nse_pkg::POS_W'(items_reg);
        end
        else if (load_top)
        begin
            top_val_reg <= rd_data_reg[SW-1:0];
            top_pos_reg <= rd_data_reg[EW-1:SW];
        end
        if (produce)
            hold_reg <= new_res;
        if ((produce || finish) && hold_valid_reg)
        begin
            out_reg <= '{position:     hold_reg.position,
                         next_smaller: hold_reg.next_smaller,
                         found:        hold_reg.found,
                         overflow:     hold_reg.overflow,
                         end_of_run:   finish};
        end
    end

    // stack memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[count_reg[AW-1:0]] <= {nse_pkg::POS_W'(items_reg), v_reg};
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### test/testbench.sv
// Testbench: streaming next-smaller-element stack checked against an in-bench stack predictor.
`timescale 1ns / 1ps

module testbench;

    localparam int SEQ_CAP        = 64;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 16;

    localparam logic signed [nse_pkg::VALUE_W-1:0] V_MIN = {1'b1, {(nse_pkg::VALUE_W-1){1'b0}}};
    localparam logic signed [nse_pkg::VALUE_W-1:0] V_MAX = {1'b0, {(nse_pkg::VALUE_W-1){1'b1}}};

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 item_valid   = 1'b0;
    logic                 item_stall;
    nse_pkg::item_req_t   item         = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    nse_pkg::result_req_t result;

    // predictor state
    logic signed [nse_pkg::VALUE_W-1:0] stack_vals [SEQ_CAP];
    logic [nse_pkg::POS_W-1:0]          stack_pos  [SEQ_CAP];
    int                                 stack_depth = 0;
    int                                 seq_len     = 0;
    nse_pkg::result_req_t               pending_answers [$];

    int fail_count   = 0;
    int send_gap_pct = 0;
    int rx_stall_pct = 0;
    int hold_asks    = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;
    nse_pkg::result_req_t want;

    next_smaller_element_stack #(
        .MAX_LEN    (SEQ_CAP),
        .VALUE_BITS (nse_pkg::VALUE_W)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void predict_answers(input nse_pkg::item_req_t req);
        nse_pkg::result_req_t answers [$];
        nse_pkg::result_req_t r;
        logic                 rejected;
        rejected = (seq_len >= SEQ_CAP);
        if (!rejected)
        begin
            while (stack_depth > 0 && $signed(req.value) < $signed(stack_vals[stack_depth-1]))
            begin
                r              = '0;
                r.position     = stack_pos[stack_depth-1];
                r.next_smaller = req.value;
                r.found        = 1'b1;
                answers.push_back(r);
                stack_depth--;
            end
            stack_vals[stack_depth] = req.value;
            stack_pos[stack_depth]  = seq_len[nse_pkg::POS_W-1:0];
            stack_depth++;
            seq_len++;
        end
        if (req.last)
        begin
            for (int i = 0; i < stack_depth; i++)
            begin
                r          = '0;
                r.position = stack_pos[i];
                r.overflow = rejected;
                answers.push_back(r);
            end
            stack_depth = 0;
            seq_len     = 0;
        end
        else if (rejected)
        begin
            r          = '0;
            r.overflow = 1'b1;
            answers.push_back(r);
        end
        if (answers.size() > 0)
            answers[answers.size()-1].end_of_run = 1'b1;
        foreach (answers[i])
            pending_answers.push_back(answers[i]);
    endfunction

    function automatic logic signed [nse_pkg::VALUE_W-1:0] pick_value(input int mode);
        logic signed [nse_pkg::VALUE_W-1:0] v;
        case (mode)
            0:
            begin
                v = $urandom_range(0, 8);
                v = v - 4;
            end
            1: v = $urandom;
            default:
            begin
                case ($urandom_range(0, 4))
                    0: v = V_MIN;
                    1: v = V_MAX;
                    2: v = '0;
                    3: v = -1;
                    default: v = $urandom;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic send_item(input logic signed [nse_pkg::VALUE_W-1:0] v, input logic lst);
        nse_pkg::item_req_t req;
        req.value = v;
        req.last  = lst;
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= req;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        predict_answers(req);
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_directed();
        send_gap_pct = 0;
        rx_stall_pct = 0;
        send_item(0, 1'b1);
        send_item(V_MAX, 1'b0);
        send_item(V_MIN, 1'b0);
        send_item(-1, 1'b0);
        send_item(-1, 1'b0);
        send_item(0, 1'b0);
        send_item(7, 1'b0);
        send_item(3, 1'b0);
        send_item(3, 1'b0);
        send_item(V_MIN, 1'b1);
        send_item(5, 1'b0);
        send_item(4, 1'b0);
        send_item(3, 1'b0);
        send_item(V_MAX, 1'b1);
        send_item(V_MIN, 1'b0);
        send_item(V_MIN, 1'b1);
        wait_drained();
    endtask

    // full-length sequence, then dropped items past capacity
    task automatic test_capacity();
        for (int k = 0; k < SEQ_CAP; k++)
            send_item(k - 32, k == SEQ_CAP - 1);
        for (int k = 0; k < SEQ_CAP; k++)
            send_item(k * 3, 1'b0);
        repeat (3) send_item(-5, 1'b0);
        send_item(V_MIN, 1'b1);
        send_item(7, 1'b0);
        send_item(2, 1'b1);
        wait_drained();
    endtask

    task automatic test_backpressure();
        send_gap_pct = 0;
        rx_stall_pct = 0;
        hold_asks++;
        for (int k = 0; k < 40; k++)
            send_item(1000 - k, 1'b0);
        send_item(0, 1'b1);
        wait_drained();
    endtask

    task automatic test_random(input int gap_pct, input int stall_pct, input int n_items);
        int sent;
        int len;
        int pick;
        int mode;
        send_gap_pct = gap_pct;
        rx_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 85)
                len = $urandom_range(1, 12);
            else if (pick < 95)
                len = $urandom_range(13, 40);
            else
                len = $urandom_range(60, 70);
            mode = $urandom_range(0, 2);
            for (int k = 0; k < len; k++)
                send_item(pick_value(mode), k == len - 1);
            sent += len;
        end
        wait_drained();
    endtask

    always @(posedge clk)
    begin
        if (hold_seen != hold_asks)
        begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_answers.size() == 0)
            begin
                $display("%0t unexpected result: pos %0d val %0d found %b ovf %b end %b",
                         $time, result.position, result.next_smaller, result.found,
                         result.overflow, result.end_of_run);
                fail_count++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (result.position !== want.position
                    || result.next_smaller !== want.next_smaller
                    || result.found !== want.found
                    || result.overflow !== want.overflow
                    || result.end_of_run !== want.end_of_run)
                begin
                    $display("%0t expected pos %0d val %0d found %b ovf %b end %b",
                             $time, want.position, want.next_smaller, want.found,
                             want.overflow, want.end_of_run);
                    $display("%0t actual   pos %0d val %0d found %b ovf %b end %b",
                             $time, result.position, result.next_smaller, result.found,
                             result.overflow, result.end_of_run);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t watchdog: no request moved for %0d cycles", $time, quiet_cycles);
                $display("next_smaller_element_stack: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_capacity();
        test_backpressure();
        test_random(0, 0, 32);
        test_random(67, 0, 32);
        test_random(0, 67, 32);
        test_random(26, 26, 32);
        if (fail_count == 0 && pending_answers.size() == 0)
            $display("next_smaller_element_stack: match");
        else
            $display("next_smaller_element_stack: mismatch");
        $finish;
    end

endmodule
